// ===== design/bga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_pkg
// Shared widths, codes and scan-unit types of the bitmap goal allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bga_pkg;

  // map geometry
  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 64;
  localparam int WORDS     = MAP_BITS / WORD_BITS;
  localparam int WORD_AW   = $clog2(WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LIM_W     = BIT_W + 1;
  localparam int IDX_W     = 13;
  localparam int SIZE_W    = 14;

  // item kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_ALREADY = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // scan unit operations
  typedef enum logic [1:0] {
    SCAN_FIRST_FREE,
    SCAN_FREE_BYTE,
    SCAN_LAST_USED
  } scan_mode_e;

  typedef struct packed {
    scan_mode_e         mode;
    logic [BIT_W-1:0]   lo;
    logic [LIM_W-1:0]   hi;
  } scan_req_t;

  typedef struct packed {
    logic               found;
    logic [BIT_W-1:0]   pos;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== design/bitmap_goal_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_goal_allocator_unit
// Goal-directed free-space bitmap allocator with free and mark operations.
// ----------------------------------------------------------------------------
// Steps: a rejected item goes straight to its result; free and mark pass
// through commit; allocate takes the goal step, then if needed a byte scan of
// up to 128 words, back-up or a linear scan of up to 128 words, and commit.
// One item at a time: input stalls until the result beat is taken, and the
// next item is accepted in the cycle after that at the earliest.
// Reset marks every map word unwritten (reads as free) and sets the size to 8192.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_goal_allocator_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  in_kind_i,
  input  wire logic [bga_pkg::IDX_W-1:0]   in_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [1:0]                  out_status_o,
  output logic      [bga_pkg::IDX_W-1:0]   out_position_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [bga_pkg::SIZE_W-1:0]  cfg_map_len_i
);

  localparam int SW = bga_pkg::SIZE_W;
  localparam int AW = bga_pkg::WORD_AW;
  localparam int BW = bga_pkg::BIT_W;
  localparam int LW = bga_pkg::LIM_W;
  localparam logic [SW-1:0] MAP_SIZE  = SW'(bga_pkg::MAP_BITS);
  localparam logic [SW-1:0] WORD_SIZE = SW'(bga_pkg::WORD_BITS);
  localparam logic [LW-1:0] WORD_LIM  = LW'(bga_pkg::WORD_BITS);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GOAL = 3'd1;
  localparam logic [2:0] S_BYTE = 3'd2;
  localparam logic [2:0] S_BACK = 3'd3;
  localparam logic [2:0] S_LIN  = 3'd4;
  localparam logic [2:0] S_CMT  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                     state_q, state_d;
  logic [SW-1:0]                  map_len_q;
  logic [1:0]                     kind_q, kind_d;
  logic [SW-1:0]                  goal_q, goal_d;
  logic [SW-1:0]                  size_q, size_d;
  logic [AW-1:0]                  addr_q, addr_d;
  logic [LW-1:0]                  lim_q, lim_d;
  logic [bga_pkg::IDX_W-1:0]      pos_q, pos_d;
  logic [1:0]                     status_q, status_d;
  logic [bga_pkg::WORDS-1:0]      valid_q;
  logic                           rd_valid_q;

  logic [bga_pkg::WORD_BITS-1:0]  rd_data;
  logic [bga_pkg::WORD_BITS-1:0]  word;
  logic [bga_pkg::WORD_BITS-1:0]  bit_mask;
  logic                           we;
  logic [bga_pkg::WORD_BITS-1:0]  wdata;
  logic [SW-1:0]                  base;
  logic [SW-1:0]                  rem;
  logic [LW-1:0]                  hi_cap;
  logic [BW-1:0]                  lo_off;
  logic                           next_ok;
  logic [SW-1:0]                  new_goal;
  logic [SW-1:0]                  hit_pos;
  logic [SW-1:0]                  back_pos;
  logic [SW-1:0]                  in_index_ext;
  bga_pkg::scan_req_t             scan_req;
  bga_pkg::scan_res_t             scan_res;

  // map storage, one 64-bit word per row
  bga_ram #(
    .WIDTH (bga_pkg::WORD_BITS),
    .DEPTH (bga_pkg::WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .raddr_i (addr_d),
    .rdata_o (rd_data)
  );

  // shared word scanner
  bga_scan u_scan (
    .word_i (word),
    .req_i  (scan_req),
    .res_o  (scan_res)
  );

  // word at addr_q; rows never written read as free
  assign word = rd_valid_q ? rd_data : '0;

  // window of the current word inside the size in use
  assign base     = {1'b0, addr_q, {BW{1'b0}}};
  assign rem      = size_q - base;
  assign hi_cap   = (rem >= WORD_SIZE) ? WORD_LIM : rem[LW-1:0];
  assign lo_off   = (addr_q == goal_q[bga_pkg::IDX_W-1:BW]) ? goal_q[BW-1:0] : '0;
  assign next_ok  = (base + WORD_SIZE) < size_q;
  assign hit_pos  = base + SW'(scan_res.pos);
  assign back_pos = base + SW'(scan_res.pos) + SW'(1);
  assign bit_mask = {{(bga_pkg::WORD_BITS-1){1'b0}}, 1'b1} << pos_q[BW-1:0];
  assign in_index_ext = {1'b0, in_index_i};

  // pick the scan operation for the current step
  always_comb begin
    scan_req.mode = bga_pkg::SCAN_FIRST_FREE;
    scan_req.lo   = lo_off;
    scan_req.hi   = hi_cap;
    if (state_q == S_BYTE) begin
      scan_req.mode = bga_pkg::SCAN_FREE_BYTE;
    end else if (state_q == S_BACK) begin
      scan_req.mode = bga_pkg::SCAN_LAST_USED;
      scan_req.lo   = '0;
      scan_req.hi   = lim_q;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    goal_d   = goal_q;
    size_d   = size_q;
    addr_d   = addr_q;
    lim_d    = lim_q;
    pos_d    = pos_q;
    status_d = status_q;
    new_goal = goal_q;
    we       = 1'b0;
    wdata    = word;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          size_d   = (map_len_q > MAP_SIZE) ? MAP_SIZE : map_len_q;
          kind_d   = in_kind_i;
          goal_d   = in_index_ext;
          pos_d    = in_index_i;
          addr_d   = in_index_i[bga_pkg::IDX_W-1:BW];
          status_d = bga_pkg::ST_OK;
          if (in_kind_i != bga_pkg::KIND_ALLOC && in_kind_i != bga_pkg::KIND_FREE
              && in_kind_i != bga_pkg::KIND_MARK) begin
            status_d = bga_pkg::ST_RANGE;
            state_d  = S_DONE;
          end else if (in_index_ext >= size_d) begin
            status_d = bga_pkg::ST_RANGE;
            state_d  = S_DONE;
          end else if (in_kind_i == bga_pkg::KIND_ALLOC) begin
            state_d = S_GOAL;
          end else begin
            state_d = S_CMT;
          end
        end
      end
      S_GOAL: begin
        // take the goal, else rest of its word, else unaligned goal moves to word end
        if (!word[goal_q[BW-1:0]]) begin
          state_d = S_CMT;
        end else if (goal_q[BW-1:0] != '0 && scan_res.found) begin
          pos_d   = hit_pos[bga_pkg::IDX_W-1:0];
          state_d = S_CMT;
        end else begin
          if (goal_q[BW-1:0] != '0) begin
            new_goal = base + SW'(hi_cap);
          end
          goal_d = new_goal;
          if ({new_goal[SW-1:3], 3'b000} < size_q) begin
            addr_d  = new_goal[bga_pkg::IDX_W-1:BW];
            state_d = S_BYTE;
          end else begin
            status_d = bga_pkg::ST_NO_FREE;
            pos_d    = '0;
            state_d  = S_DONE;
          end
        end
      end
      S_BYTE: begin
        // first wholly free byte from the goal byte on
        if (scan_res.found) begin
          lim_d   = LW'(scan_res.pos);
          state_d = S_BACK;
        end else if (next_ok) begin
          addr_d = addr_q + AW'(1);
        end else begin
          addr_d  = goal_q[bga_pkg::IDX_W-1:BW];
          state_d = S_LIN;
        end
      end
      S_BACK: begin
        // back up over the free run below the byte
        if (scan_res.found) begin
          pos_d   = back_pos[bga_pkg::IDX_W-1:0];
          addr_d  = back_pos[bga_pkg::IDX_W-1:BW];
          state_d = S_CMT;
        end else if (addr_q == '0) begin
          pos_d   = '0;
          state_d = S_CMT;
        end else begin
          addr_d = addr_q - AW'(1);
          lim_d  = WORD_LIM;
        end
      end
      S_LIN: begin
        // first free bit from the goal up to the size in use
        if (scan_res.found) begin
          pos_d   = hit_pos[bga_pkg::IDX_W-1:0];
          state_d = S_CMT;
        end else if (next_ok) begin
          addr_d = addr_q + AW'(1);
        end else begin
          status_d = bga_pkg::ST_NO_FREE;
          pos_d    = '0;
          state_d  = S_DONE;
        end
      end
      S_CMT: begin
        // update the target bit in its word
        state_d = S_DONE;
        case (kind_q)
          bga_pkg::KIND_ALLOC: begin
            we    = 1'b1;
            wdata = word | bit_mask;
          end
          bga_pkg::KIND_FREE: begin
            if ((word & bit_mask) == '0) begin
              status_d = bga_pkg::ST_ALREADY;
            end else begin
              we    = 1'b1;
              wdata = word & ~bit_mask;
            end
          end
          bga_pkg::KIND_MARK: begin
            if ((word & bit_mask) != '0) begin
              status_d = bga_pkg::ST_ALREADY;
            end else begin
              we    = 1'b1;
              wdata = word | bit_mask;
            end
          end
          default: begin
            status_d = bga_pkg::ST_RANGE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      map_len_q  <= MAP_SIZE;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= valid_q[addr_d];
      if (cfg_we_i) begin
        map_len_q <= cfg_map_len_i;
      end
      if (we) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    goal_q   <= goal_d;
    size_q   <= size_d;
    addr_q   <= addr_d;
    lim_q    <= lim_d;
    pos_q    <= pos_d;
    status_q <= status_d;
  end

  // handshake and result beat
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_DONE);
  assign out_status_o   = status_q;
  assign out_position_o = pos_q;

endmodule

`default_nettype wire

// ===== design/bga_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bga_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/bga_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_scan
// Shared word scanner: first free bit, first free byte or last used bit
// of one map word inside a window [lo, hi); last used ignores lo.
// ----------------------------------------------------------------------------
`default_nettype none

module bga_scan (
  input  wire logic [bga_pkg::WORD_BITS-1:0] word_i,
  input  wire bga_pkg::scan_req_t            req_i,
  output bga_pkg::scan_res_t                 res_o
);

  localparam int BYTES = bga_pkg::WORD_BITS / 8;

  always_comb begin
    logic                        found;
    logic [bga_pkg::BIT_W-1:0]   pos;
    logic [bga_pkg::LIM_W-1:0]   j_lim;
    logic [bga_pkg::LIM_W-1:0]   b_lim;
    found = 1'b0;
    pos   = '0;
    j_lim = '0;
    b_lim = '0;
    case (req_i.mode)
      bga_pkg::SCAN_FIRST_FREE: begin
        // walk down so the lowest hit wins
        for (int j = bga_pkg::WORD_BITS - 1; j >= 0; j--) begin
          j_lim = bga_pkg::LIM_W'(j);
          if (!word_i[j] && j_lim >= {1'b0, req_i.lo} && j_lim < req_i.hi) begin
            found = 1'b1;
            pos   = bga_pkg::BIT_W'(j);
          end
        end
      end
      bga_pkg::SCAN_FREE_BYTE: begin
        // a byte counts if it starts below hi, not below lo's byte, and is all clear
        for (int k = BYTES - 1; k >= 0; k--) begin
          b_lim = bga_pkg::LIM_W'(k * 8);
          if (word_i[k*8 +: 8] == 8'h00 && b_lim[bga_pkg::BIT_W-1:3] >= req_i.lo[bga_pkg::BIT_W-1:3]
              && b_lim < req_i.hi) begin
            found = 1'b1;
            pos   = bga_pkg::BIT_W'(k * 8);
          end
        end
      end
      bga_pkg::SCAN_LAST_USED: begin
        // walk up so the highest hit wins
        for (int j = 0; j < bga_pkg::WORD_BITS; j++) begin
          j_lim = bga_pkg::LIM_W'(j);
          if (word_i[j] && j_lim < req_i.hi) begin
            found = 1'b1;
            pos   = bga_pkg::BIT_W'(j);
          end
        end
      end
      default: begin
        found = 1'b0;
        pos   = '0;
      end
    endcase
    res_o.found = found;
    res_o.pos   = pos;
  end

endmodule

`default_nettype wire

// ===== test/bitmap_goal_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_goal_allocator_unit_test
// Self-checking bench for the goal-directed bitmap allocator. A scoreboard
// tracks its own copy of the used map and map length, predicts status and
// position for every accepted request beat, and compares each result beat in
// order. Directed requests hit the allocation search steps, range and kind
// rejects, then random phases sweep map lengths under varied idling.
// ----------------------------------------------------------------------------

module bitmap_goal_allocator_unit_test;

  localparam logic [1:0]  KIND_UNKNOWN   = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned HOLDOFF_CYCLES = 600;
  localparam int unsigned HOLDOFF_AT     = 150;
  localparam int unsigned PHASE_ITEMS    = 125;

  // Shadow of the allocator: used map, size in use, pending result beats.
  class bitmap_tracker;
    typedef struct {
      logic [1:0]                status;
      logic [bga_pkg::IDX_W-1:0] position;
    } reply_t;

    bit          used_map [bga_pkg::MAP_BITS];
    int unsigned map_len;
    reply_t      pending[$];
    int unsigned mismatches;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      map_len    = bga_pkg::MAP_BITS;
      mismatches = 0;
    endfunction

    // bits past the map read as used
    function bit is_used(int unsigned i);
      return (i >= bga_pkg::MAP_BITS) ? 1'b1 : used_map[i];
    endfunction

    function int unsigned size_in_use();
      return (map_len > bga_pkg::MAP_BITS) ? bga_pkg::MAP_BITS : map_len;
    endfunction

    function int unsigned first_free(int unsigned from, int unsigned lim);
      for (int unsigned i = from; i < lim; i++)
        if (!is_used(i)) return i;
      return lim;
    endfunction

    // Goal, rest of goal word, first free byte with back-up, linear tail.
    function bit choose_bit(int unsigned goal, int unsigned size, output int unsigned got);
      int unsigned lim;
      int unsigned f;
      int unsigned k;
      bit          whole;
      got = 0;
      if (!is_used(goal)) begin
        got = goal;
        return 1'b1;
      end
      if (goal != 0) begin
        lim = (goal + 63) & ~32'd63;
        if (lim > size) lim = size;
        f = first_free(goal, lim);
        if (f < lim) begin
          got = f;
          return 1'b1;
        end
        goal = lim;
      end
      for (int unsigned b = goal >> 3; (b << 3) < size; b++) begin
        whole = 1'b1;
        for (int unsigned j = 0; j < 8; j++)
          if (is_used((b << 3) + j)) whole = 1'b0;
        if (whole) begin
          k = b << 3;
          while (k != 0 && !is_used(k - 1)) k--;
          got = k;
          return 1'b1;
        end
      end
      f = first_free(goal, size);
      if (f < size) begin
        got = f;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Apply one accepted request beat and queue its result.
    function void note_request(logic [1:0] kind, logic [bga_pkg::IDX_W-1:0] index);
      reply_t      r;
      int unsigned size;
      int unsigned got;
      size       = size_in_use();
      r.status   = bga_pkg::ST_OK;
      r.position = index;
      if (kind == KIND_UNKNOWN || index >= size) begin
        r.status = bga_pkg::ST_RANGE;
      end else if (kind == bga_pkg::KIND_ALLOC) begin
        if (choose_bit(index, size, got)) begin
          used_map[got] = 1'b1;
          r.position    = bga_pkg::IDX_W'(got);
        end else begin
          r.status   = bga_pkg::ST_NO_FREE;
          r.position = '0;
        end
      end else if (kind == bga_pkg::KIND_FREE) begin
        if (!used_map[index]) r.status = bga_pkg::ST_ALREADY;
        else used_map[index] = 1'b0;
      end else begin
        if (used_map[index]) r.status = bga_pkg::ST_ALREADY;
        else used_map[index] = 1'b1;
      end
      pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_reply(logic [1:0] status, logic [bga_pkg::IDX_W-1:0] position);
      reply_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: status %0d position %0d", status, position);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, position);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_kind      = bga_pkg::KIND_ALLOC;
  logic [bga_pkg::IDX_W-1:0]  in_index     = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [1:0]                 out_status;
  logic [bga_pkg::IDX_W-1:0]  out_position;
  logic                       cfg_we       = 1'b0;
  logic [bga_pkg::SIZE_W-1:0] cfg_size     = bga_pkg::SIZE_W'(bga_pkg::MAP_BITS);

  bitmap_tracker tracker;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   random_sent   = 0;
  int unsigned   beats_taken   = 0;
  int unsigned   holdoff_left  = 0;
  bit            holdoff_done  = 1'b0;
  int unsigned   cycle_count   = 0;

  bitmap_goal_allocator_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_kind_i      (in_kind),
    .in_index_i     (in_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_status_o   (out_status),
    .out_position_o (out_position),
    .cfg_we_i       (cfg_we),
    .cfg_map_len_i  (cfg_size)
  );

  always #4 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Take result beats, check them, and pick the next stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_reply(out_status, out_position);
        beats_taken++;
      end
      if (!holdoff_done && beats_taken == HOLDOFF_AT) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one request beat after a random gap and hold it until accepted.
  task automatic offer_beat(input logic [1:0] kind, input logic [bga_pkg::IDX_W-1:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_index <= index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(kind, index);
  endtask

  // Drop valid and wait for every predicted result beat.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned value);
    settle();
    cfg_we   <= 1'b1;
    cfg_size <= bga_pkg::SIZE_W'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.map_len = value;
  endtask

  // Random requests at one map length; idling follows overall progress.
  task automatic run_phase(input int unsigned size);
    logic [1:0]  kind;
    int unsigned lim;
    int unsigned roll;
    int unsigned pos;
    write_size(size);
    lim = (size > bga_pkg::MAP_BITS) ? bga_pkg::MAP_BITS : size;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (random_sent < 333) begin
        send_idle_pct = 38;
        recv_idle_pct = 57;
      end else if (random_sent < 666) begin
        send_idle_pct = 57;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 50) kind = bga_pkg::KIND_ALLOC;
      else if (roll < 72) kind = bga_pkg::KIND_FREE;
      else if (roll < 96) kind = bga_pkg::KIND_MARK;
      else kind = KIND_UNKNOWN;
      roll = $urandom_range(99);
      if (roll < 8 && lim < bga_pkg::MAP_BITS) begin
        pos = $urandom_range(bga_pkg::MAP_BITS - 1, lim);
      end else if (roll < 22) begin
        // land on or next to a 64-bit word edge
        pos = $urandom_range((lim - 1) / 64) * 64;
        pos += $urandom_range(1) ? 63 - $urandom_range(1) : $urandom_range(1);
        if (pos >= lim) pos = lim - 1;
      end else begin
        pos = $urandom_range(lim - 1);
        // steer most frees toward a used bit
        if (kind == bga_pkg::KIND_FREE && roll < 75)
          for (int t = 0; t < 16 && !tracker.used_map[pos]; t++)
            pos = $urandom_range(lim - 1);
      end
      offer_beat(kind, bga_pkg::IDX_W'(pos));
      random_sent++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 57;

    // goal hits, goal-word scan, free-byte back-up, failure at the top bit
    offer_beat(bga_pkg::KIND_ALLOC, 13'd0);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd0);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd5);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd1);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd1);
    offer_beat(bga_pkg::KIND_MARK,  13'd100);
    offer_beat(bga_pkg::KIND_MARK,  13'd100);
    offer_beat(bga_pkg::KIND_FREE,  13'd100);
    offer_beat(bga_pkg::KIND_FREE,  13'd100);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd8191);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd8191);
    offer_beat(bga_pkg::KIND_MARK,  13'd63);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd63);
    offer_beat(KIND_UNKNOWN, 13'd8191);
    offer_beat(KIND_UNKNOWN, 13'd0);
    offer_beat(bga_pkg::KIND_FREE,  13'd8191);
    offer_beat(bga_pkg::KIND_MARK,  13'd4095);

    // smallest map: range rejects, linear tail scan, full map
    write_size(8);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd8);
    offer_beat(bga_pkg::KIND_FREE,  13'd8191);
    offer_beat(bga_pkg::KIND_MARK,  13'd8191);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd7);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd7);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd4);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd0);
    offer_beat(bga_pkg::KIND_ALLOC, 13'd0);

    run_phase(8);
    run_phase(64);
    run_phase(130);
    run_phase(bga_pkg::MAP_BITS);
    run_phase(257);
    run_phase(1000);
    run_phase(72);
    run_phase(8);

    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
